// ===== rtl/stump_split_search_unit_assert.svh =====
// Assertion macros for the stump split search RTL.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef STUMP_SPLIT_SEARCH_UNIT_ASSERT_SVH
`define STUMP_SPLIT_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stump_ss_pkg.sv =====
// Types and constants for the stump split search unit.
// No dependencies.
`timescale 1ns / 1ps

package stump_ss_pkg;

    localparam int DATA_W    = 24;
    localparam int SUM_W     = 36;
    localparam int SCORE_W   = 59;
    localparam int POS_W     = 12;
    localparam int ADDR_IN_W = 12;
    localparam int RANK_W    = 13;
    localparam int LO_W      = 18;
    localparam int PROD_W    = SUM_W + DATA_W;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ENTRY = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] resid;
        logic signed [DATA_W-1:0] weight;
        logic                     mask;
        logic                     last;
    } entry_t;

    typedef struct packed {
        logic           valid;
        logic [QCW-1:0] count;
    } q_status_t;

endpackage

// ===== rtl/stump_split_search_unit.sv =====
// Top level of the stump split search unit: front, entry queue and back.
// Depends on stump_ss_pkg, stump_ss_front, stump_ss_queue, stump_ss_back.
//
// Input channel: push/full. action 0 writes residual_value into slot
// load_address (ignored at or beyond MAX_ROWS); action 1 sends one sorted
// column entry (rank_index, weight, mask_bit, last_in_column).
// Result channel: empty/pop. One result (best_position, best_score) per
// column, produced by the entry with last_in_column set.
// Throughput: one item per cycle while results are drained; the running sum
// and the best-score compare each close through one register.
// A result reaches the ports through the memory read, queue, sum, split
// multiply, magnitude and compare registers, in that order.
// A load is visible to an entry accepted in the next cycle.
// Reset clears the running sum, best score, positions and the queue; the
// residual memory is not cleared and must be loaded before it is ranked.
// While a result waits and pop is low, the back end holds; up to 4 entries
// collect in the queue, then full rises until the result is taken.
`timescale 1ns / 1ps

module stump_split_search_unit #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic                                     action,
    input  logic [stump_ss_pkg::ADDR_IN_W-1:0]       load_address,
    input  logic signed [stump_ss_pkg::DATA_W-1:0]   residual_value,
    input  logic [stump_ss_pkg::RANK_W-1:0]          rank_index,
    input  logic signed [stump_ss_pkg::DATA_W-1:0]   weight,
    input  logic                                     mask_bit,
    input  logic                                     last_in_column,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [stump_ss_pkg::POS_W-1:0]           best_position,
    output logic [stump_ss_pkg::SCORE_W-1:0]         best_score
);
    import stump_ss_pkg::*;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    entry_t    q_in;
    entry_t    q_out;

    stump_ss_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .load_address   (load_address),
        .residual_value (residual_value),
        .rank_index     (rank_index),
        .weight         (weight),
        .mask_bit       (mask_bit),
        .last_in_column (last_in_column),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    stump_ss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    stump_ss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .best_position (best_position),
        .best_score    (best_score)
    );

endmodule

// ===== rtl/stump_ss_front.sv =====
// Front end: accepts items, writes loads into the residual memory and
// gathers the residual for column entries. Depends on stump_ss_pkg.
`timescale 1ns / 1ps

module stump_ss_front #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic                                     action,
    input  logic [stump_ss_pkg::ADDR_IN_W-1:0]       load_address,
    input  logic signed [stump_ss_pkg::DATA_W-1:0]   residual_value,
    input  logic [stump_ss_pkg::RANK_W-1:0]          rank_index,
    input  logic signed [stump_ss_pkg::DATA_W-1:0]   weight,
    input  logic                                     mask_bit,
    input  logic                                     last_in_column,
    input  stump_ss_pkg::q_status_t                  q_status,
    output logic                                     q_push,
    output stump_ss_pkg::entry_t                     q_data
);
    import stump_ss_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic signed [DATA_W-1:0] mem [MAX_ROWS];

    logic                     accept;
    logic                     load_ok;
    logic                     rank_ok;
    logic [31:0]              rank_m1;
    logic [31:0]              load_w;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;
    logic [QCW:0]             used;

    logic                     s1_valid_reg;
    logic                     s1_rank_ok_reg;
    logic signed [DATA_W-1:0] s1_resid_reg;
    logic signed [DATA_W-1:0] s1_weight_reg;
    logic                     s1_mask_reg;
    logic                     s1_last_reg;

    // the entry held in s1 has a slot reserved in the queue
    assign used   = {1'b0, q_status.count} + (QCW+1)'(s1_valid_reg);
    assign full   = (used >= (QCW+1)'(QDEPTH));
    assign accept = push && !full;

    assign load_w  = 32'(load_address);
    assign load_ok = (load_w < 32'(MAX_ROWS));
    assign waddr   = load_ok ? load_w[AW-1:0] : '0;

    assign rank_m1 = 32'(rank_index) - 32'd1;
    assign rank_ok = (rank_index != '0) && (32'(rank_index) <= 32'(MAX_ROWS));
    assign raddr   = rank_ok ? rank_m1[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_LOAD) && load_ok)
        begin
            mem[waddr] <= residual_value;
        end
        if (accept && (action == ACT_ENTRY))
        begin
            s1_resid_reg   <= mem[raddr];
            s1_rank_ok_reg <= rank_ok;
            s1_weight_reg  <= weight;
            s1_mask_reg    <= mask_bit;
            s1_last_reg    <= last_in_column;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (action == ACT_ENTRY);
        end
    end

    assign q_push        = s1_valid_reg;
    assign q_data.resid  = s1_rank_ok_reg ? s1_resid_reg : '0;
    assign q_data.weight = s1_weight_reg;
    assign q_data.mask   = s1_mask_reg;
    assign q_data.last   = s1_last_reg;

endmodule

// ===== rtl/stump_ss_queue.sv =====
// Short queue of gathered column entries between front and back.
// Depends on stump_ss_pkg.
`timescale 1ns / 1ps

module stump_ss_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  stump_ss_pkg::entry_t      push_data,
    input  logic                      pop,
    output stump_ss_pkg::entry_t      pop_data,
    output stump_ss_pkg::q_status_t   status
);
    import stump_ss_pkg::*;

    entry_t         slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCW'(1);
            2'b01:   count_next = count_reg - QCW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign pop_data     = slot_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.count = count_reg;

endmodule

// ===== rtl/stump_ss_back.sv =====
// Back end: running sum, split multiply, magnitude, best tracking and the
// result register. Depends on stump_ss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stump_split_search_unit_assert.svh"

module stump_ss_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stump_ss_pkg::q_status_t                q_status,
    input  stump_ss_pkg::entry_t                   q_data,
    output logic                                   q_pop,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [stump_ss_pkg::POS_W-1:0]         best_position,
    output logic [stump_ss_pkg::SCORE_W-1:0]       best_score
);
    import stump_ss_pkg::*;

    logic                      en;

    logic signed [SUM_W-1:0]   run_sum_reg;
    logic [POS_W-1:0]          pos_cnt_reg;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;

    logic                      a_valid_reg;
    logic signed [SUM_W-1:0]   a_sum_reg;
    logic signed [DATA_W-1:0]  a_weight_reg;
    logic                      a_mask_reg;
    logic                      a_last_reg;
    logic [POS_W-1:0]          a_pos_reg;

    logic signed [LO_W+DATA_W:0]         p_lo;
    logic signed [SUM_W-LO_W+DATA_W-1:0] p_hi;
    logic                                b_valid_reg;
    logic signed [LO_W+DATA_W:0]         b_plo_reg;
    logic signed [SUM_W-LO_W+DATA_W-1:0] b_phi_reg;
    logic                                b_mask_reg;
    logic                                b_last_reg;
    logic [POS_W-1:0]                    b_pos_reg;

    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  mag;
    logic                      c_valid_reg;
    logic [SCORE_W-1:0]        c_score_reg;
    logic                      c_last_reg;
    logic [POS_W-1:0]          c_pos_reg;

    logic [SCORE_W-1:0]        best_reg;
    logic [POS_W-1:0]          best_pos_reg;
    logic [SCORE_W-1:0]        best_next;
    logic [POS_W-1:0]          best_pos_next;

    logic                      res_valid_reg;
    logic [SCORE_W-1:0]        res_score_reg;
    logic [POS_W-1:0]          res_pos_reg;

    // whole back pipeline moves only when the result register can take a transfer
    assign en    = !res_valid_reg || pop;
    assign q_pop = en && q_status.valid;

    assign sum_wide = (SUM_W+1)'(run_sum_reg) + (SUM_W+1)'(q_data.resid);

    always_comb
    begin
        case ({sum_wide[SUM_W], sum_wide[SUM_W-1]})
            2'b01:   sum_sat = SUM_MAX;
            2'b10:   sum_sat = SUM_MIN;
            default: sum_sat = sum_wide[SUM_W-1:0];
        endcase
    end

    // sum split into an unsigned low part and a signed high part
    assign p_lo = (LO_W+DATA_W+1)'($signed({1'b0, a_sum_reg[LO_W-1:0]}))
                * (LO_W+DATA_W+1)'(a_weight_reg);
    assign p_hi = (SUM_W-LO_W+DATA_W)'($signed(a_sum_reg[SUM_W-1:LO_W]))
                * (SUM_W-LO_W+DATA_W)'(a_weight_reg);

    assign prod = (PROD_W'(b_phi_reg) <<< LO_W) + PROD_W'(b_plo_reg);
    assign mag  = prod[PROD_W-1] ? -prod : prod;

    always_comb
    begin
        best_next     = best_reg;
        best_pos_next = best_pos_reg;
        if (c_score_reg > best_reg)
        begin
            best_next     = c_score_reg;
            best_pos_next = c_pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sum_reg    <= sum_sat;
            a_weight_reg <= q_data.weight;
            a_mask_reg   <= q_data.mask;
            a_last_reg   <= q_data.last;
            a_pos_reg    <= pos_cnt_reg;

            b_plo_reg    <= p_lo;
            b_phi_reg    <= p_hi;
            b_mask_reg   <= a_mask_reg;
            b_last_reg   <= a_last_reg;
            b_pos_reg    <= a_pos_reg;

            c_score_reg  <= b_mask_reg ? mag[SCORE_W-1:0] : '0;
            c_last_reg   <= b_last_reg;
            c_pos_reg    <= b_pos_reg;

            res_score_reg <= best_next;
            res_pos_reg   <= best_pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg   <= '0;
            pos_cnt_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            best_reg      <= '0;
            best_pos_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= q_status.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            res_valid_reg <= c_valid_reg && c_last_reg;
            if (q_status.valid)
            begin
                run_sum_reg <= q_data.last ? '0 : sum_sat;
                pos_cnt_reg <= q_data.last ? '0 : pos_cnt_reg + POS_W'(1);
            end
            if (c_valid_reg)
            begin
                best_reg     <= c_last_reg ? '0 : best_next;
                best_pos_reg <= c_last_reg ? '0 : best_pos_next;
            end
        end
    end

    assign empty         = !res_valid_reg;
    assign best_position = res_pos_reg;
    assign best_score    = res_score_reg;

    `SS_ASSERT_NEXT(a_stall_freeze, res_valid_reg && !pop, $stable(run_sum_reg) && $stable(best_reg) && $stable(c_valid_reg), "back pipeline moved during output stall")
    `SS_ASSERT_NEXT(a_last_emits, en && c_valid_reg && c_last_reg, res_valid_reg, "last entry did not produce a result")
    `SS_ASSERT_IMPLY(a_best_bound, best_reg[SCORE_W-1], best_reg[SCORE_W-2:0] == '0, "best score above product magnitude bound")

endmodule
